// ===== hw/rtl/cmf_pkg.sv =====
// shared types and constants of the 3x3 fixed mask filter
`timescale 1ns / 1ps
`default_nettype none

package cmf_pkg;

    localparam int PIX_W         = 8;
    localparam int FW_W          = 10;
    localparam int MODE_W        = 2;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 10;
    localparam int MAX_WIDTH_DEF = 512;
    localparam int QUEUE_DEPTH   = 4;
    localparam int SUM_W         = 12;
    localparam int VAL_W         = 13;
    localparam int RECIP_W       = 13;
    localparam int RECIP_SHIFT   = 16;

    localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BORDER = 2'd3;

    localparam logic [MODE_W-1:0] MODE_EMBOSS  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BLUR    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SHARPEN = 2'd2;
    localparam logic [MODE_W-1:0] MODE_EDGE    = 2'd3;

    localparam logic [FW_W-1:0]  SIZE_RESET   = 10'd512;
    localparam logic [FW_W-1:0]  MIN_SIZE     = 10'd2;
    localparam logic [PIX_W-1:0] BORDER_RESET = 8'd127;
    localparam logic [PIX_W-1:0] MID_GRAY     = 8'd127;

    // floor(2^16 / 9) + 1, exact floor division for sums up to 2295
    localparam logic [RECIP_W-1:0] RECIP_NINE = 13'd7282;

    typedef logic [PIX_W-1:0] pixel_t;

    // index 0 top, 1 middle, 2 bottom
    typedef pixel_t [2:0] column_t;

    typedef struct packed {
        column_t left;
        column_t mid;
        column_t right;
        logic    last;
        logic    flush;
    } job_t;

endpackage

`default_nettype wire

// ===== hw/rtl/conv3x3_fixed_mask_filter.sv =====
// top level of the streaming 3x3 fixed mask image filter
//
//  channel  direction  handshake                payload
//  in       to block   in_valid / in_ready      pixel_in, drain
//  out      from block out_valid / out_ready    pixel_out, run_last, frame_last
//  cfg      to block   cfg_we (no wait)         cfg_index, cfg_data
//
// one request per clock while in_ready holds; a request at the last column gives
// two results (none in the first row), drained at one per clock while out_ready
// holds, as the job queue absorbs the burst
// line memory: one read and one write port, read registered at request accept
// reset clears counters, window and pipeline valids; the line memory is not cleared
// either side may stall; the four-entry job queue lets front and back stall apart
`timescale 1ns / 1ps
`default_nettype none

module conv3x3_fixed_mask_filter #(
    parameter int MAX_WIDTH = cmf_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [cmf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [cmf_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [cmf_pkg::PIX_W-1:0]      pixel_in,
    input  wire logic                           drain,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [cmf_pkg::PIX_W-1:0]           pixel_out,
    output logic                                run_last,
    output logic                                frame_last
);
    import cmf_pkg::*;

    logic [MODE_W-1:0] mode_reg;
    logic [FW_W-1:0]   width_reg;
    logic [FW_W-1:0]   height_reg;
    pixel_t            border_reg;

    logic  push_valid;
    logic  push_ready;
    job_t  push_job;
    logic  pop_valid;
    logic  pop_ready;
    job_t  pop_job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_EMBOSS;
            width_reg  <= SIZE_RESET;
            height_reg <= SIZE_RESET;
            border_reg <= BORDER_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MODE:
                begin
                    mode_reg <= cfg_data[MODE_W-1:0];
                end
                REG_WIDTH:
                begin
                    width_reg <= cfg_data[FW_W-1:0];
                end
                REG_HEIGHT:
                begin
                    height_reg <= cfg_data[FW_W-1:0];
                end
                default:
                begin
                    border_reg <= cfg_data[PIX_W-1:0];
                end
            endcase
        end
    end

    cmf_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame_width  (width_reg),
        .frame_height (height_reg),
        .border_value (border_reg),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .pixel_in     (pixel_in),
        .drain        (drain),
        .job_valid    (push_valid),
        .job_ready    (push_ready),
        .job          (push_job)
    );

    cmf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_job)
    );

    cmf_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .filter_mode  (mode_reg),
        .border_value (border_reg),
        .job_valid    (pop_valid),
        .job_ready    (pop_ready),
        .job          (pop_job),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pixel_out    (pixel_out),
        .run_last     (run_last),
        .frame_last   (frame_last)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/cmf_queue.sv =====
// job queue between the window front end and the filter back end
`timescale 1ns / 1ps
`default_nettype none

module cmf_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push_valid,
    output logic               push_ready,
    input  wire cmf_pkg::job_t push_data,
    output logic               pop_valid,
    input  wire logic          pop_ready,
    output cmf_pkg::job_t      pop_data
);
    import cmf_pkg::*;

    localparam int PW   = $clog2(QUEUE_DEPTH);
    localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

    job_t            slot_reg [QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [CNTW-1:0] count_reg;
    logic [PW-1:0]   wr_ptr_next;
    logic [PW-1:0]   rd_ptr_next;
    logic            push;
    logic            pop;

    assign push_ready = count_reg != CNTW'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    assign wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
    assign rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_next;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNTW'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNTW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNTW'(QUEUE_DEPTH))
        else $error("queue count past depth");

endmodule

`default_nettype wire

// ===== hw/rtl/cmf_front.sv =====
// front end: request classification, row and column counters, line memory, window
`timescale 1ns / 1ps
`default_nettype none

module cmf_front #(
    parameter int MAX_WIDTH = cmf_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic [cmf_pkg::FW_W-1:0] frame_width,
    input  wire logic [cmf_pkg::FW_W-1:0] frame_height,
    input  wire cmf_pkg::pixel_t        border_value,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire cmf_pkg::pixel_t        pixel_in,
    input  wire logic                   drain,
    output logic                        job_valid,
    input  wire logic                   job_ready,
    output cmf_pkg::job_t               job
);
    import cmf_pkg::*;

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int CMPW = (CW + 1 > FW_W) ? CW + 1 : FW_W;

    typedef struct packed {
        logic [CW-1:0] col;
        pixel_t        px;
        logic          first;
        logic          row1;
        logic          row2;
        logic          last;
        logic          flush;
    } f0_t;

    logic [CW-1:0]      col_reg;
    logic [FW_W-1:0]    row_reg;
    f0_t                f0_reg;
    f0_t                f0_next;
    logic               f0_valid_reg;
    column_t            win1_reg;
    column_t            win2_reg;
    logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] rd_reg;

    logic [CMPW-1:0] fw_ext;
    logic [CMPW-1:0] w_eff;
    logic [CMPW-1:0] col_inc;
    logic [FW_W-1:0] h_eff;
    logic            is_last;
    logic            is_flush;
    logic            take;
    logic            f0_push;
    logic            f0_move;
    column_t         cur;

    assign fw_ext = CMPW'(frame_width);

    always_comb
    begin
        if (fw_ext > CMPW'(MAX_WIDTH))
        begin
            w_eff = CMPW'(MAX_WIDTH);
        end
        else if (fw_ext < CMPW'(MIN_SIZE))
        begin
            w_eff = CMPW'(MIN_SIZE);
        end
        else
        begin
            w_eff = fw_ext;
        end
    end

    assign h_eff    = (frame_height < MIN_SIZE) ? MIN_SIZE : frame_height;
    assign col_inc  = CMPW'(col_reg) + CMPW'(1);
    assign is_last  = col_inc >= w_eff;
    assign is_flush = row_reg >= h_eff;

    // line memory word: upper byte previous row, lower byte the row before
    assign f0_push  = f0_valid_reg && !f0_reg.first && f0_reg.row1;
    assign f0_move  = f0_valid_reg && (!f0_push || job_ready);
    assign in_ready = !f0_valid_reg || f0_move;
    // mismatched drain requests are taken and dropped
    assign take     = in_valid && in_ready && (drain == is_flush);

    always_comb
    begin
        f0_next.col   = col_reg;
        f0_next.px    = is_flush ? border_value : pixel_in;
        f0_next.first = col_reg == '0;
        f0_next.row1  = row_reg != '0;
        f0_next.row2  = row_reg >= FW_W'(2);
        f0_next.last  = is_last;
        f0_next.flush = is_flush;
    end

    assign cur[0] = f0_reg.row2 ? rd_reg[PIX_W-1:0] : border_value;
    assign cur[1] = f0_reg.row1 ? rd_reg[2*PIX_W-1:PIX_W] : border_value;
    assign cur[2] = f0_reg.px;

    assign job_valid = f0_push;
    assign job.left  = win2_reg;
    assign job.mid   = win1_reg;
    assign job.right = cur;
    assign job.last  = f0_reg.last;
    assign job.flush = f0_reg.flush;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f0_valid_reg <= 1'b0;
            col_reg      <= '0;
            row_reg      <= '0;
            win1_reg     <= '0;
            win2_reg     <= '0;
        end
        else
        begin
            if (take)
            begin
                f0_valid_reg <= 1'b1;
                if (is_last)
                begin
                    col_reg <= '0;
                    row_reg <= is_flush ? '0 : row_reg + FW_W'(1);
                end
                else
                begin
                    col_reg <= col_reg + CW'(1);
                end
            end
            else if (f0_move)
            begin
                f0_valid_reg <= 1'b0;
            end
            if (f0_move)
            begin
                if (f0_reg.first)
                begin
                    win1_reg <= cur;
                    win2_reg <= {3{border_value}};
                end
                else
                begin
                    win2_reg <= win1_reg;
                    win1_reg <= cur;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            f0_reg <= f0_next;
            rd_reg <= line_mem[col_reg];
        end
        if (f0_move)
        begin
            line_mem[f0_reg.col] <= {f0_reg.px, rd_reg[2*PIX_W-1:PIX_W]};
        end
    end

    a_no_same_col: assert property (@(posedge clk) disable iff (!rst_n)
        take && f0_move |-> f0_reg.col != col_reg)
        else $error("line memory read and write hit the same column");

endmodule

`default_nettype wire

// ===== hw/rtl/cmf_back.sv =====
// back end: window sequencing, mask arithmetic, clamp and output register
`timescale 1ns / 1ps
`default_nettype none

module cmf_back (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic [cmf_pkg::MODE_W-1:0] filter_mode,
    input  wire cmf_pkg::pixel_t            border_value,
    input  wire logic                       job_valid,
    output logic                            job_ready,
    input  wire cmf_pkg::job_t              job,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output cmf_pkg::pixel_t                 pixel_out,
    output logic                            run_last,
    output logic                            frame_last
);
    import cmf_pkg::*;

    localparam int PROD_W = SUM_W + RECIP_W;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        pixel_t           p0;
        pixel_t           p3;
        pixel_t           p4;
        pixel_t           p8;
        logic             run_last;
        logic             frame_last;
    } s1_t;

    logic        second_reg;
    s1_t         s1_reg;
    s1_t         s1_next;
    logic        s1_valid_reg;
    logic        out_valid_reg;
    pixel_t      pixel_out_reg;
    logic        run_last_reg;
    logic        frame_last_reg;

    column_t     col_l;
    column_t     col_m;
    column_t     col_r;
    logic        issue;
    logic        s1_adv;
    logic        out_adv;
    logic [PROD_W-1:0] prod;
    pixel_t      quot;
    logic [VAL_W-1:0]  val;
    pixel_t      pixel_next;

    assign out_adv   = !out_valid_reg || out_ready;
    assign s1_adv    = !s1_valid_reg || out_adv;
    assign issue     = job_valid && s1_adv;
    // a line-end job yields two windows before it leaves the queue
    assign job_ready = issue && (second_reg || !job.last);

    always_comb
    begin
        if (!second_reg)
        begin
            col_l               = job.left;
            col_m               = job.mid;
            col_r               = job.right;
            s1_next.run_last    = !job.last;
            s1_next.frame_last  = 1'b0;
        end
        else
        begin
            col_l               = job.mid;
            col_m               = job.right;
            col_r               = {3{border_value}};
            s1_next.run_last    = 1'b1;
            s1_next.frame_last  = job.flush;
        end
        s1_next.sum = ((SUM_W'(col_l[0]) + SUM_W'(col_m[0])) + (SUM_W'(col_r[0])
                     + SUM_W'(col_l[1]))) + ((SUM_W'(col_m[1]) + SUM_W'(col_r[1]))
                     + (SUM_W'(col_l[2]) + SUM_W'(col_m[2]))) + SUM_W'(col_r[2]);
        s1_next.p0  = col_l[0];
        s1_next.p3  = col_l[1];
        s1_next.p4  = col_m[1];
        s1_next.p8  = col_r[2];
    end

    assign prod = PROD_W'(s1_reg.sum) * PROD_W'(RECIP_NINE);
    assign quot = prod[RECIP_SHIFT +: PIX_W];

    always_comb
    begin
        unique case (filter_mode)
            MODE_EMBOSS:
            begin
                val = VAL_W'(s1_reg.p8) - VAL_W'(s1_reg.p0) + VAL_W'(MID_GRAY);
            end
            MODE_BLUR:
            begin
                val = VAL_W'(quot);
            end
            MODE_SHARPEN:
            begin
                val = (VAL_W'(s1_reg.p4) << 3) + (VAL_W'(s1_reg.p4) << 1)
                    - VAL_W'(s1_reg.sum) + VAL_W'(MID_GRAY);
            end
            default:
            begin
                val = VAL_W'(s1_reg.p4) - VAL_W'(s1_reg.p3);
            end
        endcase
    end

    // clamp to 0..255
    always_comb
    begin
        if (val[VAL_W-1])
        begin
            pixel_next = '0;
        end
        else if (val[VAL_W-2:PIX_W] != '0)
        begin
            pixel_next = '1;
        end
        else
        begin
            pixel_next = val[PIX_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            second_reg    <= 1'b0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (issue)
            begin
                second_reg <= !second_reg && job.last;
            end
            if (s1_adv)
            begin
                s1_valid_reg <= issue;
            end
            if (out_adv)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s1_reg <= s1_next;
        end
        if (out_adv && s1_valid_reg)
        begin
            pixel_out_reg  <= pixel_next;
            run_last_reg   <= s1_reg.run_last;
            frame_last_reg <= s1_reg.frame_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign pixel_out  = pixel_out_reg;
    assign run_last   = run_last_reg;
    assign frame_last = frame_last_reg;

    a_second_has_job: assert property (@(posedge clk) disable iff (!rst_n)
        second_reg |-> job_valid)
        else $error("second window pending with empty queue");

    a_frame_end_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && frame_last_reg |-> run_last_reg)
        else $error("frame end on a result that does not close its run");

endmodule

`default_nettype wire
